// ----- hdl/rtfa_pkg.sv -----
package rtfa_pkg;

    localparam int MAX_REGIONS_DEF = 32;
    localparam int ADDR_BITS_DEF   = 48;

    localparam int MODE_W   = 3;
    localparam int KIND_W   = 3;
    localparam int ALIGN_W  = 6;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 53;

    localparam logic [63:0]        FOUR_GIB  = 64'h0000_0001_0000_0000;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_RESERVE  = 3'd2,
        MODE_FREE     = 3'd3,
        MODE_ALLOC_LO = 3'd4,
        MODE_ALLOC_HI = 3'd5,
        MODE_READ     = 3'd6,
        MODE_UNUSED   = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 3'd0,
        ST_ZERO = 3'd1,
        ST_FULL = 3'd2,
        ST_NONE = 3'd3,
        ST_OFF  = 3'd4
    } status_t;

endpackage

// ----- hdl/rtfa_ram.sv -----
module rtfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/region_table_first_fit_allocator_core.sv -----
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_data: map_enabled
// s_        in         s_tvalid/s_tready    s_tdata: one command item
// m_        out        m_tvalid/m_tready    m_tdata: one result item
//
// Add, out-of-range read and refused items pass IDLE, DISPATCH and DONE; read by index
// adds RDWAIT. Remove, reserve, free and allocation scan the region RAM one slot a cycle
// through a two-stage compare and stop at the first hit or after the last slot.
// Remove then compacts one slot a cycle over the slots behind the hit.
// Reset (aresetn low, synchronous) clears counters, totals and the enable bit;
// the region RAM is not cleared. A stalled result waits in the output register
// while the next item is taken; the following result waits until it drains.
module region_table_first_fit_allocator_core #(
    parameter int MAX_REGIONS = rtfa_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = rtfa_pkg::ADDR_BITS_DEF,
    localparam int A      = ADDR_BITS,
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1),
    localparam int S_RAW  = rtfa_pkg::MODE_W + 2 * A + rtfa_pkg::KIND_W
                            + rtfa_pkg::ALIGN_W + rtfa_pkg::SLOT_W,
    localparam int S_W    = ((S_RAW + 7) / 8) * 8,
    localparam int M_RAW  = rtfa_pkg::STATUS_W + A + (A + 1) + rtfa_pkg::KIND_W + 1
                            + CNT_W + 3 * rtfa_pkg::TOTAL_W + (A + 1) + A,
    localparam int M_W    = ((M_RAW + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    // mode, base_addr, length, region_kind, align_log2, slot_index
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // status, result_addr, result_len, result_kind, result_marked, count_out,
    // total_out, avail_out, held_out, low_end_out, high_start_out
    output logic [M_W-1:0] m_tdata
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int E_W   = 2 * A + 1 + rtfa_pkg::KIND_W + 1;
    localparam int TW    = rtfa_pkg::TOTAL_W;
    localparam logic [63:0]  ADDR_MAX64 = (64'd1 << A) - 64'd1;
    localparam logic [A-1:0] FOUR_GIB_B = A'(rtfa_pkg::FOUR_GIB);
    localparam logic [A:0]   FOUR_GIB_E = (A + 1)'(rtfa_pkg::FOUR_GIB);

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_SHIFT, S_RDWAIT, S_DONE
    } state_t;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [63:0] b);
        if (b >= 64'(rtfa_pkg::TOTAL_MAX) || 64'(a) > 64'(rtfa_pkg::TOTAL_MAX) - b) begin
            return rtfa_pkg::TOTAL_MAX;
        end
        return a + b[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] sat_sub(input logic [TW-1:0] a, input logic [63:0] b);
        if (b >= 64'(a)) begin
            return '0;
        end
        return a - b[TW-1:0];
    endfunction

    state_t                        state_reg;
    rtfa_pkg::mode_t               op_mode_reg;
    logic [A-1:0]                  op_base_reg;
    logic [A-1:0]                  op_len_reg;
    logic [rtfa_pkg::KIND_W-1:0]   op_kind_reg;
    logic [rtfa_pkg::ALIGN_W-1:0]  op_align_reg;
    logic [rtfa_pkg::SLOT_W-1:0]   op_slot_reg;
    logic                          enable_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [TW-1:0]                 total_reg, avail_reg, held_reg;
    logic [A:0]                    low_end_reg;
    logic [A-1:0]                  high_start_reg;
    rtfa_pkg::status_t             res_status_reg;
    logic [A-1:0]                  res_addr_reg;
    logic [A:0]                    res_len_reg;
    logic [rtfa_pkg::KIND_W-1:0]   res_kind_reg;
    logic                          res_mark_reg;
    logic                          m_valid_reg;
    logic [M_W-1:0]                m_data_reg;

    logic [CNT_W-1:0]              rd_ptr_reg, rd_idx_reg, s1_idx_reg, sh_ptr_reg;
    logic                          rd_v_reg, s1_v_reg, s1_ok_reg, s1_mark_reg;
    logic [A-1:0]                  s1_base_reg;
    logic [A:0]                    s1_end_reg;
    logic [rtfa_pkg::KIND_W-1:0]   s1_kind_reg;
    logic [63:0]                   s1_a_reg;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr, ram_raddr;
    logic [E_W-1:0]                ram_wdata, ram_rdata;

    logic [A-1:0]                  rd_base;
    logic [A:0]                    rd_end;
    logic [rtfa_pkg::KIND_W-1:0]   rd_kind;
    logic                          rd_mark;
    logic                          is_alloc, is_high, mark_set;
    logic [63:0]                   amask, cand_a, next2;
    logic                          contains, elig, s1_ok, fit2, hit2, last2, rd_issue;
    logic [A:0]                    add_end, hit_size;
    rtfa_pkg::status_t             disp_status;
    state_t                        disp_state;

    rtfa_ram #(.WIDTH(E_W), .DEPTH(MAX_REGIONS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign rd_base = ram_rdata[A-1:0];
    assign rd_end  = ram_rdata[2*A:A];
    assign rd_kind = ram_rdata[2*A+3:2*A+1];
    assign rd_mark = ram_rdata[2*A+4];

    assign is_alloc = (op_mode_reg == rtfa_pkg::MODE_ALLOC_LO)
                   || (op_mode_reg == rtfa_pkg::MODE_ALLOC_HI);
    assign is_high  = (op_mode_reg == rtfa_pkg::MODE_ALLOC_HI);
    assign mark_set = (op_mode_reg == rtfa_pkg::MODE_RESERVE);

    assign amask    = (64'd1 << op_align_reg) - 64'd1;
    assign cand_a   = (64'(rd_base) + amask) & ~amask;
    assign contains = (op_base_reg >= rd_base) && ({1'b0, op_base_reg} < rd_end);
    assign elig     = (rd_kind == '0) && !rd_mark
                   && (is_high ? (rd_base >= FOUR_GIB_B) : (rd_end <= FOUR_GIB_E));
    assign s1_ok    = is_alloc ? elig : contains;

    assign next2    = s1_a_reg + 64'(op_len_reg);
    assign fit2     = (next2 <= 64'(s1_end_reg)) && (next2 <= ADDR_MAX64);
    assign hit2     = s1_v_reg && s1_ok_reg && (!is_alloc || fit2);
    assign last2    = s1_v_reg && (s1_idx_reg == count_reg - CNT_W'(1));
    assign rd_issue = (rd_ptr_reg < count_reg) && !hit2;
    assign add_end  = {1'b0, op_base_reg} + {1'b0, op_len_reg};
    assign hit_size = s1_end_reg - {1'b0, s1_base_reg};

    always_comb begin
        disp_status = rtfa_pkg::ST_OK;
        disp_state  = S_DONE;
        if (op_mode_reg == rtfa_pkg::MODE_UNUSED) begin
            disp_status = rtfa_pkg::ST_NONE;
        end else if (op_mode_reg != rtfa_pkg::MODE_ADD && !enable_reg) begin
            disp_status = rtfa_pkg::ST_OFF;
        end else begin
            unique case (op_mode_reg)
                rtfa_pkg::MODE_ADD: begin
                    if (op_len_reg == '0) begin
                        disp_status = rtfa_pkg::ST_ZERO;
                    end else if (count_reg >= CNT_W'(MAX_REGIONS)) begin
                        disp_status = rtfa_pkg::ST_FULL;
                    end
                end
                rtfa_pkg::MODE_RESERVE, rtfa_pkg::MODE_FREE: begin
                    if (op_len_reg == '0) begin
                        disp_status = rtfa_pkg::ST_ZERO;
                    end else if (count_reg == '0) begin
                        disp_status = rtfa_pkg::ST_NONE;
                    end else begin
                        disp_state = S_SCAN;
                    end
                end
                rtfa_pkg::MODE_READ: begin
                    if (32'(op_slot_reg) >= 32'(count_reg)) begin
                        disp_status = rtfa_pkg::ST_NONE;
                    end else begin
                        disp_state = S_RDWAIT;
                    end
                end
                default: begin
                    if (count_reg == '0) begin
                        disp_status = rtfa_pkg::ST_NONE;
                    end else begin
                        disp_state = S_SCAN;
                    end
                end
            endcase
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = s1_idx_reg[IDX_W-1:0];
        ram_wdata = {s1_mark_reg, s1_kind_reg, s1_end_reg, s1_base_reg};
        ram_raddr = rd_ptr_reg[IDX_W-1:0];
        unique case (state_reg)
            S_DISPATCH: begin
                ram_raddr = IDX_W'(op_slot_reg);
                ram_waddr = count_reg[IDX_W-1:0];
                ram_wdata = {(op_kind_reg != '0), op_kind_reg, add_end, op_base_reg};
                ram_we    = (op_mode_reg == rtfa_pkg::MODE_ADD) && (op_len_reg != '0)
                         && (count_reg < CNT_W'(MAX_REGIONS));
            end
            S_SCAN: begin
                if (hit2) begin
                    ram_raddr = IDX_W'(s1_idx_reg + CNT_W'(1));
                    if (is_alloc) begin
                        ram_we    = 1'b1;
                        ram_wdata = {s1_mark_reg, s1_kind_reg, s1_end_reg, next2[A-1:0]};
                    end else if (op_mode_reg != rtfa_pkg::MODE_REMOVE
                                 && s1_mark_reg != mark_set) begin
                        ram_we    = 1'b1;
                        ram_wdata = {mark_set, s1_kind_reg, s1_end_reg, s1_base_reg};
                    end
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = sh_ptr_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                ram_raddr = IDX_W'(sh_ptr_reg + CNT_W'(2));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            enable_reg     <= 1'b0;
            count_reg      <= '0;
            total_reg      <= '0;
            avail_reg      <= '0;
            held_reg       <= '0;
            low_end_reg    <= '0;
            high_start_reg <= '0;
            m_valid_reg    <= 1'b0;
            rd_v_reg       <= 1'b0;
            s1_v_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                enable_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_mode_reg  <= rtfa_pkg::mode_t'(s_tdata[2:0]);
                        op_base_reg  <= s_tdata[3 +: A];
                        op_len_reg   <= s_tdata[3+A +: A];
                        op_kind_reg  <= s_tdata[3+2*A +: 3];
                        op_align_reg <= s_tdata[6+2*A +: 6];
                        op_slot_reg  <= s_tdata[12+2*A +: 5];
                        state_reg    <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    res_status_reg <= disp_status;
                    res_addr_reg   <= '0;
                    res_len_reg    <= '0;
                    res_kind_reg   <= '0;
                    res_mark_reg   <= 1'b0;
                    rd_ptr_reg     <= '0;
                    rd_v_reg       <= 1'b0;
                    s1_v_reg       <= 1'b0;
                    state_reg      <= disp_state;
                    if (op_mode_reg == rtfa_pkg::MODE_ADD && disp_status == rtfa_pkg::ST_OK) begin
                        count_reg <= count_reg + CNT_W'(1);
                        total_reg <= sat_add(total_reg, 64'(op_len_reg));
                        if (op_kind_reg == '0) begin
                            avail_reg <= sat_add(avail_reg, 64'(op_len_reg));
                        end else begin
                            held_reg <= sat_add(held_reg, 64'(op_len_reg));
                        end
                        if (op_base_reg < FOUR_GIB_B) begin
                            if (add_end > low_end_reg) begin
                                low_end_reg <= add_end;
                            end
                        end else if (high_start_reg == '0
                                     || op_base_reg < high_start_reg) begin
                            high_start_reg <= op_base_reg;
                        end
                    end
                end
                S_SCAN: begin
                    rd_v_reg    <= rd_issue;
                    rd_idx_reg  <= rd_ptr_reg;
                    if (rd_issue) begin
                        rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    end
                    s1_v_reg    <= rd_v_reg && !hit2;
                    s1_idx_reg  <= rd_idx_reg;
                    s1_ok_reg   <= s1_ok;
                    s1_base_reg <= rd_base;
                    s1_end_reg  <= rd_end;
                    s1_kind_reg <= rd_kind;
                    s1_mark_reg <= rd_mark;
                    s1_a_reg    <= cand_a;
                    if (hit2) begin
                        state_reg <= (op_mode_reg == rtfa_pkg::MODE_REMOVE
                                      && s1_idx_reg + CNT_W'(1) != count_reg)
                                     ? S_SHIFT : S_DONE;
                        if (is_alloc) begin
                            avail_reg    <= sat_sub(avail_reg, 64'(op_len_reg));
                            res_addr_reg <= s1_a_reg[A-1:0];
                        end else if (op_mode_reg == rtfa_pkg::MODE_REMOVE) begin
                            total_reg <= sat_sub(total_reg, 64'(hit_size));
                            if (s1_kind_reg == '0) begin
                                avail_reg <= sat_sub(avail_reg, 64'(hit_size));
                            end else begin
                                held_reg <= sat_sub(held_reg, 64'(hit_size));
                            end
                            if (s1_idx_reg + CNT_W'(1) == count_reg) begin
                                count_reg <= count_reg - CNT_W'(1);
                            end else begin
                                sh_ptr_reg <= s1_idx_reg;
                            end
                        end else if (s1_mark_reg == mark_set) begin
                            res_status_reg <= rtfa_pkg::ST_NONE;
                        end else if (mark_set) begin
                            avail_reg <= sat_sub(avail_reg, 64'(op_len_reg));
                            held_reg  <= sat_add(held_reg, 64'(op_len_reg));
                        end else begin
                            avail_reg <= sat_add(avail_reg, 64'(op_len_reg));
                            held_reg  <= sat_sub(held_reg, 64'(op_len_reg));
                        end
                    end else if (last2) begin
                        res_status_reg <= rtfa_pkg::ST_NONE;
                        state_reg      <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    if (sh_ptr_reg + CNT_W'(2) == count_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_DONE;
                    end else begin
                        sh_ptr_reg <= sh_ptr_reg + CNT_W'(1);
                    end
                end
                S_RDWAIT: begin
                    res_addr_reg <= rd_base;
                    res_len_reg  <= rd_end - {1'b0, rd_base};
                    res_kind_reg <= rd_kind;
                    res_mark_reg <= rd_mark;
                    state_reg    <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= M_W'({high_start_reg, low_end_reg, held_reg,
                                             avail_reg, total_reg, count_reg,
                                             res_mark_reg, res_kind_reg, res_len_reg,
                                             res_addr_reg, res_status_reg});
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/rtfa_checker.sv -----
module rtfa_checker #(
    parameter int MAX_REGIONS = rtfa_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = rtfa_pkg::ADDR_BITS_DEF,
    parameter int S_W         = 120,
    parameter int M_W         = 368
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [M_W-1:0] m_tdata
);

    localparam int A      = ADDR_BITS;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int CNT_LO = rtfa_pkg::STATUS_W + A + (A + 1) + rtfa_pkg::KIND_W + 1;

    logic [rtfa_pkg::STATUS_W-1:0] st;
    logic [A-1:0]                  addr;
    logic [CNT_W-1:0]              cnt;

    assign st   = m_tdata[rtfa_pkg::STATUS_W-1:0];
    assign addr = m_tdata[rtfa_pkg::STATUS_W +: A];
    assign cnt  = m_tdata[CNT_LO +: CNT_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st <= rtfa_pkg::ST_OFF)
        else $error("status code out of range");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(cnt) <= MAX_REGIONS)
        else $error("region count above table size");

    a_fail_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != rtfa_pkg::ST_OK |-> addr == '0)
        else $error("address on failed item");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("handshake not idle after reset");

endmodule

bind region_table_first_fit_allocator_core rtfa_checker #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_BITS   (ADDR_BITS),
    .S_W         (S_W),
    .M_W         (M_W)
) u_rtfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
